[hw/rtl/tsn_pkg.sv]
// ----------------------------------------------------------------------------
// tsn_pkg
// Shared constants, the inter-cell word type and character class helpers
// for the text sentence normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tsn_pkg;

  // Special characters
  localparam logic [7:0] TERM_BYTE  = 8'd13;
  localparam logic [7:0] BLANK_BYTE = 8'hFF;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] CASE_DELTA = 8'd32;
  localparam logic [7:0] COMMA_BYTE = 8'h2C;
  localparam logic [7:0] DOT_BYTE   = 8'h2E;
  localparam logic [7:0] SEMI_BYTE  = 8'h3B;

  // Character class bounds
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h5A;
  localparam logic [7:0] LOWER_LO = 8'h61;
  localparam logic [7:0] LOWER_HI = 8'h7A;

  // Word handed from one cell to the next
  typedef struct packed {
    logic       eot;  // terminator word
    logic [7:0] ch;   // character
  } tsn_word_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= DIGIT_LO) && (c <= DIGIT_HI);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= UPPER_LO) && (c <= UPPER_HI);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= LOWER_LO) && (c <= LOWER_HI);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == COMMA_BYTE) || (c == DOT_BYTE) || (c == SEMI_BYTE);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tsn_if.sv]
// ----------------------------------------------------------------------------
// tsn_if
// Valid/ready channel interfaces for the text input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tsn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_terminator;

  modport source (output valid, output out_byte, output is_terminator, input ready);
  modport sink   (input valid, input out_byte, input is_terminator, output ready);
endinterface

`default_nettype wire

[hw/rtl/text_sentence_normalizer_unit.sv]
// Order: a text byte waits in the lookahead cell until the word that follows
//   it is accepted; a terminator that flushes a held byte follows that byte.
// Throughput: one word per cycle while the result side is ready; a terminator
//   that flushes a held byte stalls the lookahead cell's input while it is sent.
// Reset: rst_n low synchronously clears all valid flags and the sentence state.
// ----------------------------------------------------------------------------
// text_sentence_normalizer_unit
// Chain of three cells (fold, lookahead, case) passing words with
// valid/ready between neighbors; each cell has its own output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_sentence_normalizer_unit
  import tsn_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsn_in_if.sink     in_ch,
  tsn_out_if.source  out_ch
);

  tsn_word_t in_word;
  logic      c0_valid, c0_ready;
  tsn_word_t c0_word;
  logic      c1_valid, c1_ready;
  tsn_word_t c1_word;
  logic      c2_valid;
  tsn_word_t c2_word;

  assign in_word = '{eot: in_ch.end_of_text, ch: in_ch.text_byte};

  tsn_fold_cell u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_word  (in_word),
    .up_ready (in_ch.ready),
    .dn_valid (c0_valid),
    .dn_word  (c0_word),
    .dn_ready (c0_ready)
  );

  tsn_hold_cell u_hold (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c0_valid),
    .up_word  (c0_word),
    .up_ready (c0_ready),
    .dn_valid (c1_valid),
    .dn_word  (c1_word),
    .dn_ready (c1_ready)
  );

  tsn_case_cell u_case (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c1_valid),
    .up_word  (c1_word),
    .up_ready (c1_ready),
    .dn_valid (c2_valid),
    .dn_word  (c2_word),
    .dn_ready (out_ch.ready)
  );

  // Drive the result channel from the last cell
  assign out_ch.valid         = c2_valid;
  assign out_ch.out_byte      = c2_word.ch;
  assign out_ch.is_terminator = c2_word.eot;

endmodule

`default_nettype wire

[hw/rtl/tsn_fold_cell.sv]
// ----------------------------------------------------------------------------
// tsn_fold_cell
// First cell: lowercases letters, collapses runs of equal non-digit bytes,
// drops blank markers and turns a carriage return into a terminator word.
// ----------------------------------------------------------------------------
`default_nettype none

module tsn_fold_cell
  import tsn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  input  wire tsn_word_t up_word,
  output logic           up_ready,
  output logic           dn_valid,
  output tsn_word_t      dn_word,
  input  wire logic      dn_ready
);

  logic       vld_r, vld_nxt;
  tsn_word_t  word_r, word_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       take;
  logic [7:0] lc;
  logic       rep;

  assign up_ready = !vld_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign dn_valid = vld_r;
  assign dn_word  = word_r;

  // Lowercase and compare against the previous byte
  always_comb begin
    lc       = is_upper(up_word.ch) ? (up_word.ch + CASE_DELTA) : up_word.ch;
    rep      = (lc == prev_r) && !is_digit(lc);
    vld_nxt  = vld_r && !dn_ready;
    word_nxt = word_r;
    prev_nxt = prev_r;
    if (take) begin
      if (up_word.eot || (up_word.ch == TERM_BYTE)) begin
        // terminator: pass it on and restart the run tracking
        vld_nxt  = 1'b1;
        word_nxt = '{eot: 1'b1, ch: TERM_BYTE};
        prev_nxt = SPACE_BYTE;
      end else begin
        prev_nxt = lc;
        if (!rep && (lc != BLANK_BYTE)) begin
          vld_nxt  = 1'b1;
          word_nxt = '{eot: 1'b0, ch: lc};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      prev_r <= SPACE_BYTE;
    end else begin
      vld_r  <= vld_nxt;
      prev_r <= prev_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/tsn_hold_cell.sv]
// ----------------------------------------------------------------------------
// tsn_hold_cell
// Middle cell: keeps one byte of lookahead and drops a space that is
// directly followed by a comma, period or semicolon.
// ----------------------------------------------------------------------------
`default_nettype none

module tsn_hold_cell
  import tsn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  input  wire tsn_word_t up_word,
  output logic           up_ready,
  output logic           dn_valid,
  output tsn_word_t      dn_word,
  input  wire logic      dn_ready
);

  logic       vld_r, vld_nxt;
  tsn_word_t  word_r, word_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_vld_r, held_vld_nxt;
  logic       flush_r, flush_nxt;
  logic       slot_free;
  logic       take;

  assign slot_free = !vld_r || dn_ready;
  assign up_ready  = slot_free && !flush_r;
  assign take      = up_valid && up_ready;
  assign dn_valid  = vld_r;
  assign dn_word   = word_r;

  // Release the held byte once the next byte shows whether it survives
  always_comb begin
    vld_nxt      = vld_r && !dn_ready;
    word_nxt     = word_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    flush_nxt    = flush_r;
    if (flush_r && slot_free) begin
      // terminator after the flushed byte
      vld_nxt   = 1'b1;
      word_nxt  = '{eot: 1'b1, ch: TERM_BYTE};
      flush_nxt = 1'b0;
    end else if (take) begin
      if (up_word.eot) begin
        held_vld_nxt = 1'b0;
        vld_nxt      = 1'b1;
        if (held_vld_r) begin
          word_nxt  = '{eot: 1'b0, ch: held_r};
          flush_nxt = 1'b1;
        end else begin
          word_nxt = '{eot: 1'b1, ch: TERM_BYTE};
        end
      end else begin
        if (held_vld_r && !((held_r == SPACE_BYTE) && is_punct(up_word.ch))) begin
          vld_nxt  = 1'b1;
          word_nxt = '{eot: 1'b0, ch: held_r};
        end
        held_nxt     = up_word.ch;
        held_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      held_vld_r <= 1'b0;
      flush_r    <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      held_vld_r <= held_vld_nxt;
      flush_r    <= flush_nxt;
    end
    word_r <= word_nxt;
    held_r <= held_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/tsn_case_cell.sv]
// ----------------------------------------------------------------------------
// tsn_case_cell
// Last cell: collapses runs again and capitalizes the first letter of each
// sentence; a period opens a new sentence.
// ----------------------------------------------------------------------------
`default_nettype none

module tsn_case_cell
  import tsn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  input  wire tsn_word_t up_word,
  output logic           up_ready,
  output logic           dn_valid,
  output tsn_word_t      dn_word,
  input  wire logic      dn_ready
);

  logic       vld_r, vld_nxt;
  tsn_word_t  word_r, word_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       cap_r, cap_nxt;
  logic       take;
  logic       rep;
  logic [7:0] c;

  assign up_ready = !vld_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign dn_valid = vld_r;
  assign dn_word  = word_r;

  // Collapse, then fix letter case for the sentence position
  always_comb begin
    rep      = (up_word.ch == prev_r) && !is_digit(up_word.ch);
    c        = up_word.ch;
    vld_nxt  = vld_r && !dn_ready;
    word_nxt = word_r;
    prev_nxt = prev_r;
    cap_nxt  = cap_r;
    if (take) begin
      if (up_word.eot) begin
        vld_nxt  = 1'b1;
        word_nxt = '{eot: 1'b1, ch: TERM_BYTE};
        prev_nxt = SPACE_BYTE;
        cap_nxt  = 1'b0;
      end else begin
        prev_nxt = up_word.ch;
        if (!rep) begin
          if (is_lower(up_word.ch)) begin
            if (!cap_r) begin
              c       = up_word.ch - CASE_DELTA;
              cap_nxt = 1'b1;
            end
          end else if (is_upper(up_word.ch)) begin
            if (cap_r) begin
              c = up_word.ch + CASE_DELTA;
            end else begin
              cap_nxt = 1'b1;
            end
          end else if (up_word.ch == DOT_BYTE) begin
            cap_nxt = 1'b0;
          end
          vld_nxt  = 1'b1;
          word_nxt = '{eot: 1'b0, ch: c};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      prev_r <= SPACE_BYTE;
      cap_r  <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      prev_r <= prev_nxt;
      cap_r  <= cap_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/tsn_checker.sv]
// ----------------------------------------------------------------------------
// tsn_checker
// Port-level checks on the normalizer's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tsn_checker
  import tsn_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       is_terminator
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_terminator))
    else $error("result word changed while stalled");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Terminator word carries a carriage return
  a_term_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_terminator |-> out_byte == TERM_BYTE)
    else $error("terminator word without carriage return");

  // Blank markers never reach the output
  a_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_terminator |-> out_byte != BLANK_BYTE)
    else $error("blank marker leaked to output");

endmodule

bind text_sentence_normalizer_unit tsn_checker u_tsn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .is_terminator (out_ch.is_terminator)
);

`default_nettype wire

[test/tb_text_sentence_normalizer_unit.sv]
// ----------------------------------------------------------------------------
// tb_text_sentence_normalizer_unit
// Feeds texts of random words, punctuation, digits and noise bytes, with
// directed corner cases first. Every accepted word passes through a local
// normalizer model, and every output word is checked against the oldest
// expected character. Both channels idle and stall at random. The result
// side also holds off once for a long stretch so that the chain fills up.
// ----------------------------------------------------------------------------
module tb_text_sentence_normalizer_unit
  import tsn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       term;
  } norm_char_t;

  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES  = 150;

  logic clk;
  logic rst_n;

  tsn_in_if  in_ch();
  tsn_out_if out_ch();

  text_sentence_normalizer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_item_t pending_items[$];
  norm_char_t expected_chars[$];

  int fail_count     = 0;
  int accepted_count = 0;

  // Normalizer model state
  logic [7:0] fold_prev;
  logic [7:0] held_space;
  logic       held_space_valid;
  logic [7:0] case_prev;
  logic       capital_done;

  // Handshake bookkeeping between the edges
  bit in_took  = 1'b0;
  bit out_took = 1'b0;
  bit out_hold = 1'b0;
  int in_gap   = 0;
  int out_stall = 0;
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Normalizer model
  // ---------------------------------------------------------------------------
  task automatic clear_norm_state();
    fold_prev        = SPACE_BYTE;
    held_space       = 8'h00;
    held_space_valid = 1'b0;
    case_prev        = SPACE_BYTE;
    capital_done     = 1'b0;
  endtask

  // Second collapse, then sentence capitalization
  task automatic capitalize_char(input logic [7:0] c_in);
    logic [7:0] c;
    logic       dup;
    c = c_in;
    dup = (c == case_prev) && !(c >= DIGIT_LO && c <= DIGIT_HI);
    case_prev = c;
    if (!dup) begin
      if (c >= LOWER_LO && c <= LOWER_HI) begin
        if (!capital_done) begin
          c = c - CASE_DELTA;
          capital_done = 1'b1;
        end
      end else if (c >= UPPER_LO && c <= UPPER_HI) begin
        if (capital_done) c = c + CASE_DELTA;
        else capital_done = 1'b1;
      end else if (c == DOT_BYTE) begin
        capital_done = 1'b0;
      end
      expected_chars.push_back('{ch: c, term: 1'b0});
    end
  endtask

  task automatic normalize_item(input text_item_t it);
    logic [7:0] c;
    logic       dup;
    c = it.ch;
    if (it.eot || c == TERM_BYTE) begin
      // flush a held space, emit the terminator, start over
      if (held_space_valid) capitalize_char(held_space);
      expected_chars.push_back('{ch: TERM_BYTE, term: 1'b1});
      clear_norm_state();
    end else begin
      if (c >= UPPER_LO && c <= UPPER_HI) c = c + CASE_DELTA;
      dup = (c == fold_prev) && !(c >= DIGIT_LO && c <= DIGIT_HI);
      fold_prev = c;
      if (!dup && c != BLANK_BYTE) begin
        // a held space survives unless punctuation follows it
        if (held_space_valid) begin
          held_space_valid = 1'b0;
          if (!(c == COMMA_BYTE || c == DOT_BYTE || c == SEMI_BYTE))
            capitalize_char(held_space);
        end
        if (c == SPACE_BYTE) begin
          held_space       = c;
          held_space_valid = 1'b1;
        end else begin
          capitalize_char(c);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c);
    pending_items.push_back('{ch: c, eot: 1'b0});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_eot(input logic [7:0] c);
    pending_items.push_back('{ch: c, eot: 1'b1});
  endtask

  // One text of random words with separators, punctuation and noise
  task automatic push_random_text();
    int         n_words;
    int         n_letters;
    logic [7:0] c;
    n_words = $urandom_range(1, 8);
    for (int w = 0; w < n_words; w++) begin
      n_letters = $urandom_range(1, 7);
      for (int k = 0; k < n_letters; k++) begin
        c = LOWER_LO + 8'($urandom_range(0, 25));
        if ($urandom_range(0, 9) < 3) c = c - CASE_DELTA;
        push_byte(c);
        if ($urandom_range(0, 9) == 0) push_byte(c);
      end
      case ($urandom_range(0, 11))
        0, 1, 2, 3: push_text(" ");
        4:          push_text(". ");
        5:          push_text(" , ");
        6:          push_text(" ;");
        7:          push_text("  .  ");
        8: begin
          push_byte(DIGIT_LO + 8'($urandom_range(0, 9)));
          push_byte(DIGIT_LO + 8'($urandom_range(0, 9)));
        end
        9:          push_byte(BLANK_BYTE);
        10:         push_byte(8'($urandom_range(0, 255)));
        default:    push_byte(8'($urandom_range(33, 126)));
      endcase
    end
    if ($urandom_range(0, 5) == 0) push_byte(TERM_BYTE);
    else push_eot(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Sender: advance to the next word after acceptance, hold otherwise
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.text_byte   <= 8'h00;
      in_ch.end_of_text <= 1'b0;
    end else if (!(in_ch.valid && !in_took)) begin
      in_took = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= pending_items[0].ch;
        in_ch.end_of_text <= pending_items[0].eot;
        if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each word, plus the long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_took) begin
        out_took = 1'b0;
        if ($urandom_range(0, 49) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 8);
      end
      if (out_hold) begin
        out_ch.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Hold off the result side while the sender keeps offering words
  initial begin
    wait (accepted_count >= 400);
    @(posedge clk);
    out_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict accepted input words, check accepted output words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    norm_char_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        normalize_item(pending_items.pop_front());
        accepted_count++;
        in_took = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_took = 1'b1;
        if (expected_chars.size() == 0) begin
          $error("unexpected word: out_byte %0h is_terminator %0b",
                 out_ch.out_byte, out_ch.is_terminator);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_byte !== want.ch) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.ch, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.is_terminator !== want.term) begin
            $error("is_terminator mismatch: expected %0b, actual %0b",
                   want.term, out_ch.is_terminator);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int directed_count;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    clear_norm_state();

    // Directed: leading space, case bounds, neighbors of the letter ranges,
    // digit runs, blank marker, repeats, space before punctuation, high
    // bytes, NUL, space before the end, carriage return inside the text
    push_text(" AZz@[`{11");
    push_byte(BLANK_BYTE);
    push_text("bb , . ;");
    push_byte(8'h80);
    push_byte(8'h80);
    push_byte(8'h00);
    push_text(" ");
    push_eot(8'hA5);
    push_text("q");
    push_byte(TERM_BYTE);
    directed_count = pending_items.size();

    while (pending_items.size() < directed_count + RANDOM_ITEMS) push_random_text();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending_items.size() == 0);
    wait (expected_chars.size() == 0);
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
